// ----- rtl/fsn_pkg.sv -----
package fsn_pkg;

  localparam int MaxLayers = 8;
  localparam int LayerW = $clog2(MaxLayers + 1);
  localparam int DivW = 48;
  localparam int DivDigits = DivW / 8;

  localparam logic [47:0] SkewBias   = 48'h1800_0000_0000;
  localparam logic [47:0] SkewSub    = 48'h0800_0000_0000;
  localparam logic [47:0] UnskewBias = 48'h6000_0000_0000;
  localparam logic [47:0] UnskewSub  = 48'h2000_0000_0000;
  localparam logic [49:0] RLimit     = 50'd2577006592;
  localparam logic [16:0] AmpOne     = 17'd65536;

  localparam logic [23:0] CornerAdd [4] = '{24'd0, 24'd10923, 24'd21845, 24'd32768};

  localparam logic [7:0] Perm [256] = '{
    8'd151, 8'd160, 8'd137, 8'd91, 8'd90, 8'd15, 8'd131, 8'd13, 8'd201, 8'd95, 8'd96, 8'd53,
    8'd194, 8'd233, 8'd7, 8'd225, 8'd140, 8'd36, 8'd103, 8'd30, 8'd69, 8'd142, 8'd8, 8'd99,
    8'd37, 8'd240, 8'd21, 8'd10, 8'd23, 8'd190, 8'd6, 8'd148, 8'd247, 8'd120, 8'd234, 8'd75,
    8'd0, 8'd26, 8'd197, 8'd62, 8'd94, 8'd252, 8'd219, 8'd203, 8'd117, 8'd35, 8'd11, 8'd32,
    8'd57, 8'd177, 8'd33, 8'd88, 8'd237, 8'd149, 8'd56, 8'd87, 8'd174, 8'd20, 8'd125, 8'd136,
    8'd171, 8'd168, 8'd68, 8'd175, 8'd74, 8'd165, 8'd71, 8'd134, 8'd139, 8'd48, 8'd27, 8'd166,
    8'd77, 8'd146, 8'd158, 8'd231, 8'd83, 8'd111, 8'd229, 8'd122, 8'd60, 8'd211, 8'd133,
    8'd230, 8'd220, 8'd105, 8'd92, 8'd41, 8'd55, 8'd46, 8'd245, 8'd40, 8'd244, 8'd102,
    8'd143, 8'd54, 8'd65, 8'd25, 8'd63, 8'd161, 8'd1, 8'd216, 8'd80, 8'd73, 8'd209, 8'd76,
    8'd132, 8'd187, 8'd208, 8'd89, 8'd18, 8'd169, 8'd200, 8'd196, 8'd135, 8'd130, 8'd116,
    8'd188, 8'd159, 8'd86, 8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3, 8'd64,
    8'd52, 8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5, 8'd202, 8'd38, 8'd147, 8'd118,
    8'd126, 8'd255, 8'd82, 8'd85, 8'd212, 8'd207, 8'd206, 8'd59, 8'd227, 8'd47, 8'd16,
    8'd58, 8'd17, 8'd182, 8'd189, 8'd28, 8'd42, 8'd223, 8'd183, 8'd170, 8'd213, 8'd119,
    8'd248, 8'd152, 8'd2, 8'd44, 8'd154, 8'd163, 8'd70, 8'd221, 8'd153, 8'd101, 8'd155,
    8'd167, 8'd43, 8'd172, 8'd9, 8'd129, 8'd22, 8'd39, 8'd253, 8'd19, 8'd98, 8'd108, 8'd110,
    8'd79, 8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104, 8'd218, 8'd246, 8'd97,
    8'd228, 8'd251, 8'd34, 8'd242, 8'd193, 8'd238, 8'd210, 8'd144, 8'd12, 8'd191, 8'd179,
    8'd162, 8'd241, 8'd81, 8'd51, 8'd145, 8'd235, 8'd249, 8'd14, 8'd239, 8'd107, 8'd49,
    8'd192, 8'd214, 8'd31, 8'd181, 8'd199, 8'd106, 8'd157, 8'd184, 8'd84, 8'd204, 8'd176,
    8'd115, 8'd121, 8'd50, 8'd45, 8'd127, 8'd4, 8'd150, 8'd254, 8'd138, 8'd236, 8'd205,
    8'd93, 8'd222, 8'd114, 8'd67, 8'd29, 8'd24, 8'd72, 8'd243, 8'd141, 8'd128, 8'd195,
    8'd78, 8'd66, 8'd215, 8'd61, 8'd156, 8'd180
  };

  typedef enum logic [2:0] {
    RegBaseFreq  = 3'd0,
    RegFreqGain  = 3'd1,
    RegAmpGain   = 3'd2,
    RegOctaves   = 3'd3,
    RegFloor     = 3'd4,
    RegStrength  = 3'd5,
    RegOffset    = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [23:0] base_freq;
    logic [23:0] freq_gain;
    logic [15:0] amp_gain;
    logic [23:0] floor_val;
    logic [23:0] strength;
    logic [47:0] offset;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic [LayerW-1:0]  layers;
  } item_t;

  typedef struct packed {
    logic       busy;
    logic [1:0] out_cnt;
  } back_stat_t;

endpackage

// ----- rtl/fsn_div3.sv -----
module fsn_div3 (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [fsn_pkg::DivW-1:0] dividend_i,
  output logic                    done_o,
  output logic [fsn_pkg::DivW-1:0] quot_o
);

  logic [fsn_pkg::DivW-1:0] num_q, num_d;
  logic [1:0] rem_q, rem_d;
  logic [2:0] cnt_q;
  logic       run_q, done_q;
  logic [7:0] qbits;
  logic [2:0] t;

  always_comb begin
    rem_d = rem_q;
    qbits = '0;
    t = '0;
    for (int b = 0; b < 8; b++) begin
      t = {rem_d, num_q[fsn_pkg::DivW-1-b]};
      if (t >= 3'd3) begin
        rem_d = 2'(t - 3'd3);
        qbits[7-b] = 1'b1;
      end else begin
        rem_d = t[1:0];
      end
    end
    num_d = {num_q[fsn_pkg::DivW-9:0], qbits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
        rem_q <= '0;
      end else if (run_q) begin
        rem_q <= rem_d;
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q == 3'(fsn_pkg::DivDigits - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
    end else if (run_q) begin
      num_q <= num_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

// ----- rtl/fsn_front.sv -----
module fsn_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic signed [31:0]          point_x_i,
  input  logic signed [31:0]          point_y_i,
  input  logic signed [31:0]          point_z_i,
  input  logic [3:0]                  octave_count_i,
  output logic                        valid_o,
  output fsn_pkg::item_t              item_o,
  input  logic                        take_i,
  output logic [1:0]                  count_o
);

  fsn_pkg::item_t q_q [2];
  fsn_pkg::item_t in_item;
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic wr, rd;

  always_comb begin
    in_item.px = point_x_i;
    in_item.py = point_y_i;
    in_item.pz = point_z_i;
    if (octave_count_i > fsn_pkg::LayerW'(fsn_pkg::MaxLayers)) begin
      in_item.layers = fsn_pkg::LayerW'(fsn_pkg::MaxLayers);
    end else begin
      in_item.layers = fsn_pkg::LayerW'(octave_count_i);
    end
  end

  assign full    = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = q_q[rp_q];
  assign count_o = cnt_q;
  assign wr = push && !full;
  assign rd = take_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (wr) begin
        wp_q <= !wp_q;
      end
      if (rd) begin
        rp_q <= !rp_q;
      end
      cnt_q <= 2'(cnt_q + {1'b0, wr} - {1'b0, rd});
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      q_q[wp_q] <= in_item;
    end
  end

endmodule

// ----- rtl/fsn_back.sv -----
module fsn_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fsn_pkg::cfg_t        cfg_i,
  input  logic                 valid_i,
  input  fsn_pkg::item_t       item_i,
  output logic                 take_o,
  output logic                 empty,
  input  logic                 pop,
  output logic signed [31:0]   elevation_o,
  output fsn_pkg::back_stat_t  stat_o
);

  typedef enum logic [18:0] {
    SIdle = 19'd1 << 0,
    SMul  = 19'd1 << 1,
    SSum  = 19'd1 << 2,
    SDiv1 = 19'd1 << 3,
    SCell = 19'd1 << 4,
    SDiv2 = 19'd1 << 5,
    SOrd  = 19'd1 << 6,
    SH0   = 19'd1 << 7,
    SH1   = 19'd1 << 8,
    SH2   = 19'd1 << 9,
    SSq   = 19'd1 << 10,
    SR    = 19'd1 << 11,
    SB    = 19'd1 << 12,
    SC    = 19'd1 << 13,
    SG    = 19'd1 << 14,
    STerm = 19'd1 << 15,
    SAcc  = 19'd1 << 16,
    SFin1 = 19'd1 << 17,
    SFin2 = 19'd1 << 18
  } state_e;

  state_e state_q, state_d;

  fsn_pkg::item_t item_q;
  logic [fsn_pkg::LayerW-1:0] oct_q;
  logic [23:0] freq_q;
  logic [16:0] amp_q;
  logic signed [39:0] total_q;
  logic signed [41:0] xs_q, ys_q, zs_q;
  logic signed [43:0] s_q;
  logic [15:0] fx_q, fy_q, fz_q;
  logic [7:0] ci_q, cj_q, ck_q;
  logic signed [23:0] x0_q, y0_q, z0_q;
  logic [2:0] o1_q, o2_q;
  logic [1:0] cidx_q;
  logic [7:0] ha_q, hb_q, hh_q;
  logic signed [23:0] xc_q, yc_q, zc_q;
  logic signed [49:0] sq_q;
  logic [15:0] a_q, b_q, c_q;
  logic signed [24:0] g_q;
  logic signed [43:0] acc_q;
  logic signed [51:0] term_q;
  logic [48:0] fin_q;

  logic signed [31:0] oq_q [2];
  logic owp_q, orp_q;
  logic [1:0] ocnt_q;
  logic opush, opop;

  logic div_start, div_done;
  logic [47:0] div_in, div_q;

  logic signed [56:0] mx, my, mz;
  logic signed [41:0] cxo, cyo, czo;
  logic signed [43:0] ssum;
  logic signed [44:0] wx, wy, wz;
  logic signed [30:0] nsum;
  logic [47:0] tval, x0w, y0w, z0w, sext48;
  logic [2:0] coff;
  logic signed [23:0] xc, yc, zc;
  logic signed [47:0] qx, qy, qz;
  logic signed [49:0] rr;
  logic [3:0] h;
  logic signed [24:0] gu, gv;
  logic [31:0] aa, bb;
  logic signed [41:0] cg;
  logic signed [32:0] noise;
  logic signed [51:0] termp;
  logic [47:0] fprod;
  logic [32:0] aprod;
  logic signed [40:0] dd;
  logic [24:0] dpos;
  logic signed [49:0] elev;
  logic signed [31:0] elev_sat;

  assign take_o = (state_q == SIdle) && valid_i;
  assign opush = (state_q == SFin2) && (ocnt_q != 2'd2);
  assign opop  = pop && (ocnt_q != 2'd0);
  assign empty = (ocnt_q == 2'd0);
  assign elevation_o = oq_q[orp_q];
  assign stat_o.busy = (state_q != SIdle);
  assign stat_o.out_cnt = ocnt_q;

  assign div_start = (state_q == SSum) || (state_q == SCell);
  assign div_in = (state_q == SSum) ? (48'(ssum) + fsn_pkg::SkewBias)
                                    : (48'($signed({nsum, 15'd0})) + fsn_pkg::UnskewBias);

  fsn_div3 u_div3 (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_in),
    .done_o     (div_done),
    .quot_o     (div_q)
  );

  always_comb begin
    mx = item_q.px * $signed({1'b0, freq_q});
    my = item_q.py * $signed({1'b0, freq_q});
    mz = item_q.pz * $signed({1'b0, freq_q});
    cxo = 42'($signed({cfg_i.offset[15:0], 8'h00}));
    cyo = 42'($signed({cfg_i.offset[31:16], 8'h00}));
    czo = 42'($signed({cfg_i.offset[47:32], 8'h00}));
    ssum = 44'(xs_q) + 44'(ys_q) + 44'(zs_q);
    wx = 45'(xs_q) + 45'(s_q);
    wy = 45'(ys_q) + 45'(s_q);
    wz = 45'(zs_q) + 45'(s_q);
    nsum = 31'($signed(wx[44:16])) + 31'($signed(wy[44:16])) + 31'($signed(wz[44:16]));
    tval = div_q - fsn_pkg::UnskewSub;
    sext48 = 48'(s_q);
    x0w = {32'd0, fx_q} - sext48 + tval;
    y0w = {32'd0, fy_q} - sext48 + tval;
    z0w = {32'd0, fz_q} - sext48 + tval;

    unique case (cidx_q)
      2'd0: coff = 3'b000;
      2'd1: coff = o1_q;
      2'd2: coff = o2_q;
      default: coff = 3'b111;
    endcase
    xc = x0_q - (coff[2] ? 24'sd65536 : 24'sd0) + $signed(fsn_pkg::CornerAdd[cidx_q]);
    yc = y0_q - (coff[1] ? 24'sd65536 : 24'sd0) + $signed(fsn_pkg::CornerAdd[cidx_q]);
    zc = z0_q - (coff[0] ? 24'sd65536 : 24'sd0) + $signed(fsn_pkg::CornerAdd[cidx_q]);
    if (cidx_q == 2'd3) begin
      xc = x0_q - 24'sd32768;
      yc = y0_q - 24'sd32768;
      zc = z0_q - 24'sd32768;
    end

    qx = xc_q * xc_q;
    qy = yc_q * yc_q;
    qz = zc_q * zc_q;
    rr = $signed(fsn_pkg::RLimit) - sq_q;
    h = hh_q[3:0];
    gu = (h < 4'd8) ? 25'(xc_q) : 25'(yc_q);
    if (h < 4'd4) begin
      gv = 25'(yc_q);
    end else if (h == 4'd12 || h == 4'd14) begin
      gv = 25'(xc_q);
    end else begin
      gv = 25'(zc_q);
    end
    aa = a_q * a_q;
    bb = b_q * b_q;
    cg = $signed({1'b0, c_q}) * g_q;
    noise = acc_q[43:11];
    termp = 34'(noise + 33'sd65536) * $signed({1'b0, amp_q});
    fprod = freq_q * cfg_i.freq_gain;
    aprod = amp_q * cfg_i.amp_gain;
    dd = 41'(total_q) - $signed({17'd0, cfg_i.floor_val});
    dpos = dd[40] ? 25'd0 : dd[24:0];
    elev = 50'sd65536 - $signed({17'd0, fin_q[48:16]});
    if (elev[49] && !(&elev[48:31])) begin
      elev_sat = 32'sh8000_0000;
    end else begin
      elev_sat = elev[31:0];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SIdle: if (valid_i) begin
        state_d = (item_i.layers == '0) ? SFin1 : SMul;
      end
      SMul:  state_d = SSum;
      SSum:  state_d = SDiv1;
      SDiv1: if (div_done) begin
        state_d = SCell;
      end
      SCell: state_d = SDiv2;
      SDiv2: if (div_done) begin
        state_d = SOrd;
      end
      SOrd:  state_d = SH0;
      SH0:   state_d = SH1;
      SH1:   state_d = SH2;
      SH2:   state_d = SSq;
      SSq:   state_d = SR;
      SR:    state_d = SB;
      SB:    state_d = SC;
      SC:    state_d = SG;
      SG:    state_d = (cidx_q == 2'd3) ? STerm : SH0;
      STerm: state_d = SAcc;
      SAcc:  state_d = (oct_q + 1'b1 < item_q.layers) ? SMul : SFin1;
      SFin1: state_d = SFin2;
      SFin2: if (ocnt_q != 2'd2) begin
        state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      owp_q   <= 1'b0;
      orp_q   <= 1'b0;
      ocnt_q  <= '0;
    end else begin
      state_q <= state_d;
      if (opush) begin
        owp_q <= !owp_q;
      end
      if (opop) begin
        orp_q <= !orp_q;
      end
      ocnt_q <= 2'(ocnt_q + {1'b0, opush} - {1'b0, opop});
    end
  end

  always_ff @(posedge clk_i) begin
    if (opush) begin
      oq_q[owp_q] <= elev_sat;
    end
    unique case (state_q)
      SIdle: begin
        item_q  <= item_i;
        oct_q   <= '0;
        freq_q  <= cfg_i.base_freq;
        amp_q   <= fsn_pkg::AmpOne;
        total_q <= '0;
      end
      SMul: begin
        xs_q <= 42'($signed(mx[56:16])) + cxo;
        ys_q <= 42'($signed(my[56:16])) + cyo;
        zs_q <= 42'($signed(mz[56:16])) + czo;
      end
      SDiv1: s_q <= 44'(div_q - fsn_pkg::SkewSub);
      SCell: begin
        fx_q <= wx[15:0];
        fy_q <= wy[15:0];
        fz_q <= wz[15:0];
        ci_q <= wx[23:16];
        cj_q <= wy[23:16];
        ck_q <= wz[23:16];
      end
      SDiv2: begin
        x0_q <= x0w[23:0];
        y0_q <= y0w[23:0];
        z0_q <= z0w[23:0];
      end
      SOrd: begin
        cidx_q <= '0;
        acc_q  <= '0;
        if (x0_q >= y0_q) begin
          if (y0_q >= z0_q) begin
            o1_q <= 3'b100; o2_q <= 3'b110;
          end else if (x0_q >= z0_q) begin
            o1_q <= 3'b100; o2_q <= 3'b101;
          end else begin
            o1_q <= 3'b001; o2_q <= 3'b101;
          end
        end else begin
          if (y0_q < z0_q) begin
            o1_q <= 3'b001; o2_q <= 3'b011;
          end else if (x0_q < z0_q) begin
            o1_q <= 3'b010; o2_q <= 3'b011;
          end else begin
            o1_q <= 3'b010; o2_q <= 3'b110;
          end
        end
      end
      SH0: begin
        ha_q <= fsn_pkg::Perm[ck_q + {7'd0, coff[0]}];
        xc_q <= xc;
        yc_q <= yc;
        zc_q <= zc;
      end
      SH1: hb_q <= fsn_pkg::Perm[cj_q + {7'd0, coff[1]} + ha_q];
      SH2: hh_q <= fsn_pkg::Perm[ci_q + {7'd0, coff[2]} + hb_q];
      SSq: sq_q <= 50'(qx) + 50'(qy) + 50'(qz);
      SR: begin
        a_q <= rr[49] ? 16'd0 : rr[31:16];
        g_q <= (h[0] ? -gu : gu) + (h[1] ? -gv : gv);
      end
      SB: b_q <= aa[31:16];
      SC: c_q <= bb[31:16];
      SG: begin
        acc_q  <= acc_q + 44'(cg);
        cidx_q <= cidx_q + 2'd1;
      end
      STerm: begin
        term_q <= termp;
        freq_q <= (|fprod[47:40]) ? 24'hFF_FFFF : fprod[39:16];
        amp_q  <= aprod[32:16];
      end
      SAcc: begin
        total_q <= total_q + 40'($signed(term_q[51:17]));
        oct_q   <= oct_q + 1'b1;
      end
      SFin1: fin_q <= dpos * cfg_i.strength;
      default: begin
      end
    endcase
  end

endmodule

// ----- rtl/fractal_simplex_noise_3d_core.sv -----
// Fractal 3D simplex noise elevation core.
// Input channel: a point (point_x_i/y_i/z_i, signed Q16.16) transfers when push is
// high and full is low. A two-entry front queue holds points while the back end works.
// Output channel: elevation_o (signed Q16.16) is valid while empty is low and
// transfers when pop is high; a two-entry result queue decouples the receiver.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i (0..6);
// index 7 is ignored. Write only while no point is in flight.
// Each octave runs a scale step, a skew sum step, a divide-by-3 pass, a cell step,
// a second divide-by-3 pass, an order step, four corners of 8 steps through one
// shared gradient datapath and two accumulate steps; this sequencer sets the rate,
// one point at a time: the back end takes a new point only once it is idle again.
// Reset: queues empty, registers to defaults (frequency 1.0, gain 2.0,
// persistence 0.5, one octave, floor 0, strength 1.0, zero offset).
// When pop stays low, results collect in the result queue; with it full the back
// end holds its finished result and the front queue then fills and raises full.
module fractal_simplex_noise_3d_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic signed [31:0] point_z_i,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] elevation_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [47:0]        cfg_data_i
);

  fsn_pkg::cfg_t cfg_q;
  logic [3:0] octaves_q;
  fsn_pkg::item_t item;
  fsn_pkg::back_stat_t stat;
  logic item_valid, item_take;
  logic [1:0] front_cnt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_freq <= 24'd65536;
      cfg_q.freq_gain <= 24'd131072;
      cfg_q.amp_gain  <= 16'd32768;
      cfg_q.floor_val <= 24'd0;
      cfg_q.strength  <= 24'd65536;
      cfg_q.offset    <= 48'd0;
      octaves_q       <= 4'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fsn_pkg::RegBaseFreq: cfg_q.base_freq <= cfg_data_i[23:0];
        fsn_pkg::RegFreqGain: cfg_q.freq_gain <= cfg_data_i[23:0];
        fsn_pkg::RegAmpGain:  cfg_q.amp_gain  <= cfg_data_i[15:0];
        fsn_pkg::RegOctaves:  octaves_q       <= cfg_data_i[3:0];
        fsn_pkg::RegFloor:    cfg_q.floor_val <= cfg_data_i[23:0];
        fsn_pkg::RegStrength: cfg_q.strength  <= cfg_data_i[23:0];
        fsn_pkg::RegOffset:   cfg_q.offset    <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  fsn_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .point_x_i      (point_x_i),
    .point_y_i      (point_y_i),
    .point_z_i      (point_z_i),
    .octave_count_i (octaves_q),
    .valid_o        (item_valid),
    .item_o         (item),
    .take_i         (item_take),
    .count_o        (front_cnt)
  );

  fsn_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .valid_i     (item_valid),
    .item_i      (item),
    .take_o      (item_take),
    .empty       (empty),
    .pop         (pop),
    .elevation_o (elevation_o),
    .stat_o      (stat)
  );

`ifndef SYNTH
  a_out_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.out_cnt != 2'd3) else $error("result queue overflow");
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty == (stat.out_cnt == 2'd0)) else $error("empty mismatch");
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full == (front_cnt == 2'd2)) else $error("full mismatch");
  a_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!stat.busy && front_cnt != 2'd0) |=> stat.busy) else $error("item not taken");
`endif

endmodule
